// ===== sv/assert_macros.svh =====
// Assertion helpers for the projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PWTS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("projection assertion failed");
`define PWTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("projection assertion failed");
`else
`define PWTS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PWTS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/pwts_pkg.sv =====
`timescale 1ns / 1ps
package pwts_pkg;

    localparam int WORLD_BITS_DEF = 24;
    localparam int COEF_BITS_DEF  = 32;
    localparam int CLIP_BITS      = 64;
    localparam int FRAC_BITS      = 24;
    localparam int NUM_COEF       = 12;
    localparam int COEF_IDX_BITS  = 4;
    localparam int ROW_STRIDE     = 4;
    localparam int SIZE_BITS      = 14;
    localparam int HALF_BITS      = 13;
    localparam int CFG_IDX_BITS   = 2;
    localparam int SCR_BITS       = 16;
    localparam int SCR_QBITS      = 17;
    localparam int DIST_BITS      = 20;
    localparam int DIST_QBITS     = 20;
    localparam int DIST_DEN_BITS  = 7;
    localparam int DIST_IN_BITS   = CLIP_BITS - FRAC_BITS;

    // Divide by 100 as a multiply by ceil(2^34 / 100) and a shift; exact for
    // every numerator below 2^30, and the numerator stays below 100 * 2^20.
    localparam int DIST_NUM_BITS   = 27;
    localparam int DIST_RECIP_BITS = 28;
    localparam int DIST_SHIFT      = 34;

    localparam logic [CLIP_BITS-1:0]     W_MIN       = CLIP_BITS'(1678);
    localparam logic [DIST_DEN_BITS-1:0] DIST_DIV    = DIST_DEN_BITS'(100);
    localparam logic [DIST_RECIP_BITS-1:0] DIST_RECIP = DIST_RECIP_BITS'(171798692);
    localparam logic [DIST_BITS-1:0]     DIST_MAX    = '1;
    localparam logic [SIZE_BITS-1:0]     WIDTH_RST   = SIZE_BITS'(1920);
    localparam logic [SIZE_BITS-1:0]     HEIGHT_RST  = SIZE_BITS'(1080);

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_PROJECT = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE   = 2'd2;

    typedef struct packed {
        logic                 vis;
        logic                 neg_x;
        logic                 neg_y;
        logic                 sat_x;
        logic                 sat_y;
        logic [HALF_BITS-1:0] half_x;
        logic [HALF_BITS-1:0] half_y;
    } scr_side_t;

    typedef struct packed {
        logic                       vis;
        logic signed [SCR_BITS-1:0] sx;
        logic signed [SCR_BITS-1:0] sy;
    } scr_res_t;

    // Center plus floored signed offset, clamped to 16 bits.
    function automatic logic signed [SCR_BITS-1:0] screen_coord(
        input logic                 vis,
        input logic                 sat,
        input logic                 neg,
        input logic [HALF_BITS-1:0] half,
        input logic [SCR_QBITS-1:0] quo,
        input logic                 rem_nz
    );
        logic signed [SCR_QBITS+1:0] sum;
        sum = '0;
        if (!vis) begin
            return '0;
        end
        if (sat) begin
            return neg ? SCR_BITS'(-32768) : SCR_BITS'(32767);
        end
        if (neg) begin
            sum = $signed({6'b0, half}) - $signed({2'b0, quo})
                - $signed((SCR_QBITS+2)'(rem_nz));
        end else begin
            sum = $signed({6'b0, half}) + $signed({2'b0, quo});
        end
        if (sum > 32767) begin
            return SCR_BITS'(32767);
        end
        if (sum < -32768) begin
            return SCR_BITS'(-32768);
        end
        return sum[SCR_BITS-1:0];
    endfunction

endpackage

// ===== sv/pwts_div.sv =====
`timescale 1ns / 1ps
module pwts_div #(
    parameter int NUM_BITS = pwts_pkg::DIST_DEN_BITS + pwts_pkg::DIST_QBITS,
    parameter int DEN_BITS = pwts_pkg::DIST_DEN_BITS,
    parameter int Q_BITS   = pwts_pkg::DIST_QBITS
) (
    input  logic                clk,
    input  logic                en,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic [Q_BITS-1:0]   quo,
    output logic                rem_nz
);
    localparam int R_BITS = DEN_BITS + Q_BITS;

    logic [R_BITS-1:0]   rem_reg [Q_BITS];
    logic [Q_BITS-1:0]   quo_reg [Q_BITS];
    logic [DEN_BITS-1:0] den_reg [Q_BITS-1];

    // One quotient bit per stage, most significant first.
    for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
        logic [R_BITS-1:0]   rem_in;
        logic [R_BITS-1:0]   trial;
        logic [DEN_BITS-1:0] den_in;
        logic [Q_BITS-1:0]   quo_in;

        if (k == 0) begin : g_first
            assign rem_in = R_BITS'(num);
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = R_BITS'(den_in) << (Q_BITS - 1 - k);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[k] <= rem_in - trial;
                    quo_reg[k] <= quo_in | (Q_BITS'(1) << (Q_BITS - 1 - k));
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    quo_reg[k] <= quo_in;
                end
            end
        end

        if (k < Q_BITS - 1) begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo    = quo_reg[Q_BITS-1];
    assign rem_nz = |rem_reg[Q_BITS-1];

endmodule

// ===== sv/pwts_sqrt.sv =====
`timescale 1ns / 1ps
module pwts_sqrt #(
    parameter int IN_BITS = 2 * (pwts_pkg::WORLD_BITS_DEF + 1) + 2
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [IN_BITS-1:0]   val,
    output logic [IN_BITS/2-1:0] root
);
    localparam int RB = IN_BITS / 2;

    logic [RB+1:0]      rem_reg  [RB-1];
    logic [IN_BITS-1:0] val_reg  [RB-1];
    logic [RB-1:0]      root_reg [RB];

    // Two radicand bits per stage; one root bit out of each.
    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RB+1:0]      rem_in;
        logic [RB-1:0]      root_in;
        logic [IN_BITS-1:0] val_in;
        logic [RB+1:0]      shifted;
        logic [RB+1:0]      trial;
        logic               take;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = val;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign val_in  = val_reg[k-1];
        end

        assign shifted = {rem_in[RB-1:0], val_in[IN_BITS-1-2*k -: 2]};
        assign trial   = {root_in, 2'b01};
        assign take    = shifted >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {root_in[RB-2:0], take};
            end
        end

        if (k < RB - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? shifted - trial : shifted;
                    val_reg[k] <= val_in;
                end
            end
        end
    end

    assign root = root_reg[RB-1];

endmodule

// ===== sv/perspective_world_to_screen_top.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Perspective projection of world points to screen pixels through a stored
// row-vector view matrix. A load transfer (req_type 0) writes one of twelve
// Q8.24 coefficients (slots above eleven are dropped) and returns nothing; a
// project transfer (req_type 1) returns one result: visible, screen_x,
// screen_y and distance. The block takes one transfer every cycle and holds
// the whole pipeline only while a finished result sits on the output with
// out_stall high. A projection passes through the stages in order: three
// stages form the products, the clip sums and the magnitudes, then the
// square root of the Euclidean distance takes one stage per root bit
// (ROOT_BITS = WORLD_BITS + 2 up to 32), the divide-by-100 is one
// reciprocal multiply stage, and the output register adds one more; the
// screen divider (17 bits) runs alongside and is delayed to match. A load
// takes effect for every project transfer accepted after it. Write
// screen_width, screen_height and distance_mode only while no projection
// is in flight.
module perspective_world_to_screen_top #(
    parameter int WORLD_BITS = pwts_pkg::WORLD_BITS_DEF,
    parameter int COEF_BITS  = pwts_pkg::COEF_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [pwts_pkg::COEF_IDX_BITS-1:0]  coef_index,
    input  logic signed [COEF_BITS-1:0]         coef_value,
    input  logic signed [WORLD_BITS-1:0]        target_x,
    input  logic signed [WORLD_BITS-1:0]        target_y,
    input  logic signed [WORLD_BITS-1:0]        target_z,
    input  logic signed [WORLD_BITS-1:0]        viewer_x,
    input  logic signed [WORLD_BITS-1:0]        viewer_y,
    input  logic signed [WORLD_BITS-1:0]        viewer_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                visible,
    output logic signed [pwts_pkg::SCR_BITS-1:0] screen_x,
    output logic signed [pwts_pkg::SCR_BITS-1:0] screen_y,
    output logic [pwts_pkg::DIST_BITS-1:0]      distance,
    input  logic                                cfg_write,
    input  logic [pwts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [pwts_pkg::SIZE_BITS-1:0]      cfg_data
);
    localparam int CLIP      = pwts_pkg::CLIP_BITS;
    localparam int PROD_BITS = WORLD_BITS + COEF_BITS;
    localparam int DIFF_BITS = WORLD_BITS + 1;
    localparam int SQ_FULL   = 2 * DIFF_BITS + 2;
    localparam int SUM_BITS  = (SQ_FULL > CLIP) ? CLIP : SQ_FULL;
    localparam int ROOT_BITS = SUM_BITS / 2;
    localparam int HB        = pwts_pkg::HALF_BITS;
    localparam int SQB       = pwts_pkg::SCR_QBITS;
    localparam int PNUM_BITS = CLIP + HB;
    localparam int DIN_BITS  = pwts_pkg::DIST_IN_BITS;
    localparam int DNB       = pwts_pkg::DIST_NUM_BITS;
    localparam int DPROD_BITS = pwts_pkg::DIST_NUM_BITS + pwts_pkg::DIST_RECIP_BITS;
    // Stage at which each path has its answer.
    localparam int SCR_DONE  = 4 + SQB;
    localparam int DIST_DONE = 4 + ROOT_BITS;
    localparam int SCR_DLY   = DIST_DONE - SCR_DONE;
    localparam int LAT       = DIST_DONE + 1;

    // Advance everything unless a result is waiting on a stalled output.
    logic adv;
    logic in_xfer;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign in_xfer  = in_valid && adv;

    // ---------------- configuration and coefficient store ----------------
    logic [pwts_pkg::SIZE_BITS-1:0] width_reg;
    logic [pwts_pkg::SIZE_BITS-1:0] height_reg;
    logic                           mode_reg;
    logic signed [COEF_BITS-1:0]    coef_reg [pwts_pkg::NUM_COEF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pwts_pkg::WIDTH_RST;
            height_reg <= pwts_pkg::HEIGHT_RST;
            mode_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pwts_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                pwts_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                pwts_pkg::CFG_MODE:   mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pwts_pkg::NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (in_xfer && req_type == pwts_pkg::REQ_LOAD &&
                 coef_index < pwts_pkg::COEF_IDX_BITS'(pwts_pkg::NUM_COEF))
        begin
            coef_reg[coef_index] <= coef_value;
        end
    end

    // ---------------- valid bits ----------------
    logic [LAT-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAT-2:0], in_xfer && req_type == pwts_pkg::REQ_PROJECT};
        end
    end

    // ---------------- stage 1: products and differences ----------------
    logic signed [WORLD_BITS-1:0] tgt  [3];
    logic signed [WORLD_BITS-1:0] view [3];
    logic signed [PROD_BITS-1:0]  prod [9];
    logic signed [DIFF_BITS-1:0]  diff [3];

    logic signed [CLIP-1:0]  a_prod_reg  [9];
    logic signed [CLIP-1:0]  a_trans_reg [3];
    logic [DIFF_BITS-1:0]    a_adiff_reg [3];

    assign tgt[0]  = target_x;
    assign tgt[1]  = target_y;
    assign tgt[2]  = target_z;
    assign view[0] = viewer_x;
    assign view[1] = viewer_y;
    assign view[2] = viewer_z;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod[3*r+j] = tgt[j] * coef_reg[pwts_pkg::ROW_STRIDE*r+j];
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            diff[j] = DIFF_BITS'(tgt[j]) - DIFF_BITS'(view[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 9; i++)
            begin
                a_prod_reg[i] <= CLIP'(prod[i]);
            end
            for (int r = 0; r < 3; r++)
            begin
                a_trans_reg[r] <= CLIP'(coef_reg[pwts_pkg::ROW_STRIDE*r+3]);
            end
            for (int j = 0; j < 3; j++)
            begin
                a_adiff_reg[j] <= diff[j][DIFF_BITS-1] ? DIFF_BITS'(-diff[j])
                                                       : DIFF_BITS'(diff[j]);
            end
        end
    end

    // ---------------- stage 2: clip sums and squares ----------------
    logic [2*DIFF_BITS-1:0] sq [3];
    logic signed [CLIP-1:0] b_clip_reg [3];
    logic [SUM_BITS-1:0]    b_sq_reg   [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sq[j] = a_adiff_reg[j] * a_adiff_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                b_clip_reg[r] <= a_prod_reg[3*r] + a_prod_reg[3*r+1]
                               + a_prod_reg[3*r+2] + a_trans_reg[r];
            end
            for (int j = 0; j < 3; j++)
            begin
                b_sq_reg[j] <= SUM_BITS'(sq[j]);
            end
        end
    end

    // ---------------- stage 3: signs, magnitudes, visibility ----------------
    logic signed [CLIP-1:0] neg_cy;
    assign neg_cy = -b_clip_reg[1];

    logic                c_vis_reg;
    logic                c_negx_reg;
    logic                c_negy_reg;
    logic [CLIP-1:0]     c_magx_reg;
    logic [CLIP-1:0]     c_magy_reg;
    logic [CLIP-1:0]     c_w_reg;
    logic [DIN_BITS-1:0] c_wdist_reg;
    logic [SUM_BITS-1:0] c_sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_vis_reg   <= !b_clip_reg[2][CLIP-1] && (b_clip_reg[2] >= $signed(pwts_pkg::W_MIN));
            c_negx_reg  <= b_clip_reg[0][CLIP-1];
            c_negy_reg  <= neg_cy[CLIP-1];
            c_magx_reg  <= b_clip_reg[0][CLIP-1] ? CLIP'(-b_clip_reg[0]) : CLIP'(b_clip_reg[0]);
            c_magy_reg  <= neg_cy[CLIP-1] ? CLIP'(-neg_cy) : CLIP'(neg_cy);
            c_w_reg     <= CLIP'(b_clip_reg[2]);
            c_wdist_reg <= b_clip_reg[2][CLIP-1] ? '0
                         : b_clip_reg[2][CLIP-1:pwts_pkg::FRAC_BITS];
            c_sum_reg   <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
        end
    end

    // ---------------- stage 4: offset numerators ----------------
    logic [HB-1:0]        half_x;
    logic [HB-1:0]        half_y;
    logic [PNUM_BITS-1:0] d_px_reg;
    logic [PNUM_BITS-1:0] d_py_reg;
    logic [CLIP-1:0]      d_w_reg;
    logic [HB-1:0]        d_hx_reg;
    logic [HB-1:0]        d_hy_reg;
    logic                 d_vis_reg;
    logic                 d_negx_reg;
    logic                 d_negy_reg;

    assign half_x = width_reg[pwts_pkg::SIZE_BITS-1:1];
    assign half_y = height_reg[pwts_pkg::SIZE_BITS-1:1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_px_reg   <= c_magx_reg * half_x;
            d_py_reg   <= c_magy_reg * half_y;
            d_w_reg    <= c_w_reg;
            d_hx_reg   <= half_x;
            d_hy_reg   <= half_y;
            d_vis_reg  <= c_vis_reg;
            d_negx_reg <= c_negx_reg;
            d_negy_reg <= c_negy_reg;
        end
    end

    // ---------------- screen dividers ----------------
    // Quotient of 2^17 or more always clamps: flag it, divide the rest.
    logic [CLIP+SQB-1:0]  w_limit;
    pwts_pkg::scr_side_t  side_new;
    pwts_pkg::scr_side_t  side_reg [SQB];
    logic [SQB-1:0]       quo_x;
    logic [SQB-1:0]       quo_y;
    logic                 nz_x;
    logic                 nz_y;

    assign w_limit = {d_w_reg, SQB'(0)};

    always_comb
    begin
        side_new.vis    = d_vis_reg;
        side_new.neg_x  = d_negx_reg;
        side_new.neg_y  = d_negy_reg;
        side_new.sat_x  = (CLIP+SQB)'(d_px_reg) >= w_limit;
        side_new.sat_y  = (CLIP+SQB)'(d_py_reg) >= w_limit;
        side_new.half_x = d_hx_reg;
        side_new.half_y = d_hy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_new;
            for (int k = 1; k < SQB; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    pwts_div #(
        .NUM_BITS (PNUM_BITS),
        .DEN_BITS (CLIP),
        .Q_BITS   (SQB)
    ) u_div_x (
        .clk    (clk),
        .en     (adv),
        .num    (d_px_reg),
        .den    (d_w_reg),
        .quo    (quo_x),
        .rem_nz (nz_x)
    );

    pwts_div #(
        .NUM_BITS (PNUM_BITS),
        .DEN_BITS (CLIP),
        .Q_BITS   (SQB)
    ) u_div_y (
        .clk    (clk),
        .en     (adv),
        .num    (d_py_reg),
        .den    (d_w_reg),
        .quo    (quo_y),
        .rem_nz (nz_y)
    );

    // Form pixel coordinates, then hold them until the distance catches up.
    pwts_pkg::scr_side_t side_out;
    pwts_pkg::scr_res_t  scr_new;
    pwts_pkg::scr_res_t  scr_reg [SCR_DLY];

    assign side_out = side_reg[SQB-1];

    always_comb
    begin
        scr_new.vis = side_out.vis;
        scr_new.sx  = pwts_pkg::screen_coord(side_out.vis, side_out.sat_x, side_out.neg_x,
                                             side_out.half_x, quo_x, nz_x);
        scr_new.sy  = pwts_pkg::screen_coord(side_out.vis, side_out.sat_y, side_out.neg_y,
                                             side_out.half_y, quo_y, nz_y);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scr_reg[0] <= scr_new;
            for (int k = 1; k < SCR_DLY; k++)
            begin
                scr_reg[k] <= scr_reg[k-1];
            end
        end
    end

    // ---------------- distance ----------------
    logic [ROOT_BITS-1:0]  root;
    logic [DIN_BITS-1:0]   wdist_reg [ROOT_BITS];
    logic [DIN_BITS-1:0]   dist_in;
    logic                  dist_sat;
    logic [DPROD_BITS-1:0] e_dprod_reg;
    logic                  e_dsat_reg;

    pwts_sqrt #(
        .IN_BITS (SUM_BITS)
    ) u_sqrt (
        .clk  (clk),
        .en   (adv),
        .val  (c_sum_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wdist_reg[0] <= c_wdist_reg;
            for (int k = 1; k < ROOT_BITS; k++)
            begin
                wdist_reg[k] <= wdist_reg[k-1];
            end
        end
    end

    // Anything at or above 100 * 2^20 saturates; below that the reciprocal
    // multiply gives the exact floor of the divide by 100.
    assign dist_in  = mode_reg ? wdist_reg[ROOT_BITS-1] : DIN_BITS'(root);
    assign dist_sat = dist_in >= {pwts_pkg::DIST_DIV, pwts_pkg::DIST_BITS'(0)};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_dprod_reg <= dist_in[DNB-1:0] * pwts_pkg::DIST_RECIP;
            e_dsat_reg  <= dist_sat;
        end
    end

    // ---------------- output register ----------------
    pwts_pkg::scr_res_t scr_out;
    assign scr_out = scr_reg[SCR_DLY-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            visible  <= scr_out.vis;
            screen_x <= scr_out.sx;
            screen_y <= scr_out.sy;
            distance <= e_dsat_reg ? pwts_pkg::DIST_MAX
                      : e_dprod_reg[pwts_pkg::DIST_SHIFT +: pwts_pkg::DIST_BITS];
        end
    end

    assign out_valid = v_reg[LAT-1];

    // ---------------- checks ----------------
    `PWTS_ASSERT_NEXT(a_load_no_result, clk, rst_n,
        in_valid && !in_stall && req_type == pwts_pkg::REQ_LOAD, !v_reg[0])
    `PWTS_ASSERT_IMPL(a_hidden_zero, clk, rst_n,
        out_valid && !visible, screen_x == 0 && screen_y == 0)
    `PWTS_ASSERT_IMPL(a_stall_only_blocked, clk, rst_n,
        in_stall, out_valid && out_stall)

endmodule

// ===== tb/sv/projection_checker.sv =====
`timescale 1ns / 1ps
module projection_checker (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic                                      in_stall,
    input  logic                                      req_type,
    input  logic [pwts_pkg::COEF_IDX_BITS-1:0]        coef_index,
    input  logic signed [pwts_pkg::COEF_BITS_DEF-1:0]  coef_value,
    input  logic signed [pwts_pkg::WORLD_BITS_DEF-1:0] target_x,
    input  logic signed [pwts_pkg::WORLD_BITS_DEF-1:0] target_y,
    input  logic signed [pwts_pkg::WORLD_BITS_DEF-1:0] target_z,
    input  logic signed [pwts_pkg::WORLD_BITS_DEF-1:0] viewer_x,
    input  logic signed [pwts_pkg::WORLD_BITS_DEF-1:0] viewer_y,
    input  logic signed [pwts_pkg::WORLD_BITS_DEF-1:0] viewer_z,
    input  logic                                      out_valid,
    input  logic                                      out_stall,
    input  logic                                      visible,
    input  logic signed [pwts_pkg::SCR_BITS-1:0]      screen_x,
    input  logic signed [pwts_pkg::SCR_BITS-1:0]      screen_y,
    input  logic [pwts_pkg::DIST_BITS-1:0]            distance,
    input  logic                                      cfg_write,
    input  logic [pwts_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [pwts_pkg::SIZE_BITS-1:0]            cfg_data,
    output int                                        fail_count,
    output int                                        pending
);

    localparam int WB = pwts_pkg::WORLD_BITS_DEF;

    typedef struct packed {
        logic                                 vis;
        logic signed [pwts_pkg::SCR_BITS-1:0] sx;
        logic signed [pwts_pkg::SCR_BITS-1:0] sy;
        logic [pwts_pkg::DIST_BITS-1:0]       dist_val;
    } pixel_t;

    pixel_t          pixel_q[$];
    logic [63:0]     view_coef[pwts_pkg::NUM_COEF];
    logic [pwts_pkg::SIZE_BITS-1:0] width_r;
    logic [pwts_pkg::SIZE_BITS-1:0] height_r;
    logic            mode_r;
    int              fails;

    function automatic logic [63:0] widen(input logic [WB-1:0] v);
        return {{(64-WB){v[WB-1]}}, v};
    endfunction

    function automatic logic [63:0] gap_abs(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        return d[63] ? (64'd0 - d) : d;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // floor(num * h / w) with saturation on huge quotients
    function automatic longint offset_floor(input logic [63:0] num,
                                            input logic [pwts_pkg::HALF_BITS-1:0] h,
                                            input logic [63:0] w);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] r;
        neg = num[63];
        mag = neg ? (64'd0 - num) : num;
        if (h == 0) return 0;
        if (mag / w >= (64'd1 << 17)) return neg ? -(longint'(1) << 18) : (longint'(1) << 18);
        prod = {64'd0, mag} * {115'd0, h};
        q = prod / {64'd0, w};
        r = prod % {64'd0, w};
        if (neg) return -longint'(q[63:0]) - longint'(r != 0);
        return longint'(q[63:0]);
    endfunction

    function automatic logic signed [pwts_pkg::SCR_BITS-1:0] clamp_pixel(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[pwts_pkg::SCR_BITS-1:0];
    endfunction

    function automatic pixel_t project_point();
        pixel_t      p;
        logic [63:0] x, y, z, cx, cy, w, d, dx, dy, dz;
        logic [pwts_pkg::HALF_BITS-1:0] hx, hy;
        x  = widen(target_x);
        y  = widen(target_y);
        z  = widen(target_z);
        cx = view_coef[0] * x + view_coef[1] * y + view_coef[2] * z + view_coef[3];
        cy = view_coef[4] * x + view_coef[5] * y + view_coef[6] * z + view_coef[7];
        w  = view_coef[8] * x + view_coef[9] * y + view_coef[10] * z + view_coef[11];
        if (mode_r) begin
            d = w[63] ? 64'd0 : w / (64'd100 << pwts_pkg::FRAC_BITS);
        end else begin
            dx = gap_abs(x, widen(viewer_x));
            dy = gap_abs(y, widen(viewer_y));
            dz = gap_abs(z, widen(viewer_z));
            d  = root64(dx * dx + dy * dy + dz * dz) / 64'd100;
        end
        if (d > 64'(pwts_pkg::DIST_MAX)) d = 64'(pwts_pkg::DIST_MAX);
        p.dist_val = d[pwts_pkg::DIST_BITS-1:0];
        p.vis  = !w[63] && (w >= pwts_pkg::W_MIN);
        p.sx   = '0;
        p.sy   = '0;
        if (p.vis) begin
            hx = width_r[pwts_pkg::SIZE_BITS-1:1];
            hy = height_r[pwts_pkg::SIZE_BITS-1:1];
            p.sx = clamp_pixel(longint'(hx) + offset_floor(cx, hx, w));
            p.sy = clamp_pixel(longint'(hy) + offset_floor(64'd0 - cy, hy, w));
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pixel_t e;
        if (!rst_n) begin
            for (int i = 0; i < pwts_pkg::NUM_COEF; i++) view_coef[i] = '0;
            width_r  = pwts_pkg::WIDTH_RST;
            height_r = pwts_pkg::HEIGHT_RST;
            mode_r   = 1'b0;
            pixel_q.delete();
            fails    = 0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    pwts_pkg::CFG_WIDTH:  width_r  = cfg_data;
                    pwts_pkg::CFG_HEIGHT: height_r = cfg_data;
                    pwts_pkg::CFG_MODE:   mode_r   = cfg_data[0];
                    default:    ;
                endcase
            end
            if (in_valid && !in_stall) begin
                if (req_type == pwts_pkg::REQ_LOAD) begin
                    if (coef_index < pwts_pkg::NUM_COEF)
                        view_coef[coef_index] = {{32{coef_value[31]}}, coef_value};
                end else begin
                    pixel_q = {pixel_q, project_point()};
                end
            end
            if (out_valid && !out_stall) begin
                if (pixel_q.size() == 0) begin
                    $error("result with no projection pending");
                    fails++;
                end else begin
                    e = pixel_q.pop_front();
                    if (visible !== e.vis) begin
                        $error("visible expected %0d got %0d", e.vis, visible);
                        fails++;
                    end
                    if (screen_x !== e.sx) begin
                        $error("screen_x expected %0d got %0d", e.sx, screen_x);
                        fails++;
                    end
                    if (screen_y !== e.sy) begin
                        $error("screen_y expected %0d got %0d", e.sy, screen_y);
                        fails++;
                    end
                    if (distance !== e.dist_val) begin
                        $error("distance expected %0d got %0d", e.dist_val, distance);
                        fails++;
                    end
                end
            end
        end
        fail_count <= fails;
        pending    <= pixel_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

    localparam int IDLE_LIMIT  = 5000;   // cycles with no transfer before giving up
    localparam int DRAIN_WAIT  = 60;     // longer than the pipeline
    localparam int PHASE_ITEMS = 140;
    localparam int ONE_Q24     = 1 << 24;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic req_type;
    logic [pwts_pkg::COEF_IDX_BITS-1:0] coef_index;
    logic signed [pwts_pkg::COEF_BITS_DEF-1:0]  coef_value;
    logic signed [pwts_pkg::WORLD_BITS_DEF-1:0] target_x, target_y, target_z;
    logic signed [pwts_pkg::WORLD_BITS_DEF-1:0] viewer_x, viewer_y, viewer_z;
    logic out_valid;
    logic out_stall;
    logic visible;
    logic signed [pwts_pkg::SCR_BITS-1:0] screen_x, screen_y;
    logic [pwts_pkg::DIST_BITS-1:0] distance;
    logic cfg_write;
    logic [pwts_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [pwts_pkg::SIZE_BITS-1:0] cfg_data;

    int fail_count;
    int pending;
    int idle_cycles;
    int burst_left;
    bit hold_req;

    perspective_world_to_screen_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .coef_index(coef_index), .coef_value(coef_value),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .viewer_x(viewer_x), .viewer_y(viewer_y), .viewer_z(viewer_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .visible(visible), .screen_x(screen_x), .screen_y(screen_y),
        .distance(distance),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    projection_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .coef_index(coef_index), .coef_value(coef_value),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .viewer_x(viewer_x), .viewer_y(viewer_y), .viewer_z(viewer_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .visible(visible), .screen_x(screen_x), .screen_y(screen_y),
        .distance(distance),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Free-running clock, 12 ns period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: any cycle with a transfer on either channel or a register
    // write restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: stall in segments of random style; on request hold off for
    // a long stretch so the pipeline fills and backs up into the input.
    initial
    begin : receiver
        int seg_left;
        int style;
        seg_left  = 0;
        style     = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(10, 80);
                    style    = $urandom_range(0, 3);
                end
                seg_left--;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // Offer one transfer and hold it until the block takes it.
    task automatic offer(input logic rt, input logic [3:0] ci, input logic [31:0] cv,
                         input logic [23:0] tx, input logic [23:0] ty, input logic [23:0] tz,
                         input logic [23:0] vx, input logic [23:0] vy, input logic [23:0] vz);
        in_valid   <= 1'b1;
        req_type   <= rt;
        coef_index <= ci;
        coef_value <= cv;
        target_x   <= tx;
        target_y   <= ty;
        target_z   <= tz;
        viewer_x   <= vx;
        viewer_y   <= vy;
        viewer_z   <= vz;
        do @(posedge clk); while (in_stall);
        // Insert a gap between bursts.
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic load_coef(input logic [3:0] ci, input logic [31:0] cv);
        offer(pwts_pkg::REQ_LOAD, ci, cv, 24'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic project(input logic [23:0] tx, input logic [23:0] ty, input logic [23:0] tz,
                           input logic [23:0] vx, input logic [23:0] vy, input logic [23:0] vz);
        offer(pwts_pkg::REQ_PROJECT, 4'($urandom), $urandom, tx, ty, tz, vx, vy, vz);
    endtask

    // Drop valid and wait until every projection has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pwts_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [pwts_pkg::SIZE_BITS-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return 24'($urandom);
            1:       return 24'($urandom_range(0, 8191)) - 24'd4096;
            2:       return 24'($urandom_range(0, 1 << 20));
            default: return 24'($urandom_range(0, 255)) - 24'd128;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9)) inside
            [0:3]:   return $urandom_range(0, 1 << 25);
            [4:6]:   return 32'($urandom_range(0, 1 << 26)) - 32'(1 << 25);
            [7:8]:   return $urandom;
            default: return '0;
        endcase
    endfunction

    // Random transfer: mostly projections, some coefficient loads, a few
    // loads to slots that do not exist.
    task automatic random_item();
        logic [3:0] ci;
        if ($urandom_range(0, 4) == 0)
        begin
            ci = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(12, 15))
                                             : 4'($urandom_range(0, 11));
            load_coef(ci, pick_coef());
        end
        else
            project(pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), pick_coord());
    endtask

    initial
    begin : stimulus
        logic [pwts_pkg::SIZE_BITS-1:0] widths[6];
        logic [pwts_pkg::SIZE_BITS-1:0] heights[6];
        widths  = '{14'd1920, 14'd0, 14'd8192, 14'd16383, 14'd1, 14'd640};
        heights = '{14'd1080, 14'd1, 14'd8192, 14'd16383, 14'd0, 14'd480};

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = pwts_pkg::REQ_LOAD;
        coef_index = '0;
        coef_value = '0;
        target_x   = '0;
        target_y   = '0;
        target_z   = '0;
        viewer_x   = '0;
        viewer_y   = '0;
        viewer_z   = '0;
        cfg_write  = 1'b0;
        cfg_index  = pwts_pkg::CFG_WIDTH;
        cfg_data   = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: simple camera where clip x = x, clip y = y, clip w = z.
        load_coef(4'd0, ONE_Q24);
        load_coef(4'd5, ONE_Q24);
        load_coef(4'd10, ONE_Q24);
        load_coef(4'd15, 32'h8000_0000);                 // slot does not exist
        project(24'd500, -24'd300, 24'd1000, 24'd0, 24'd0, 24'd0);
        project(24'd0, 24'd0, -24'd5, 24'd1, 24'd2, 24'd3);  // behind the viewer
        project(24'h7F_FFFF, 24'h80_0000, 24'd1, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000);
        project(24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h80_0000);
        // Threshold on w: exactly at it, then one below.
        load_coef(4'd10, 32'd0);
        load_coef(4'd11, 32'd1678);
        project(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        load_coef(4'd11, 32'd1677);
        project(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        load_coef(4'd3, 32'h7FFF_FFFF);
        load_coef(4'd7, 32'h8000_0000);
        load_coef(4'd11, ONE_Q24);
        project(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        drain();

        // Directed: w distance, with negative w.
        write_reg(pwts_pkg::CFG_MODE, 14'd1);
        load_coef(4'd10, -ONE_Q24);
        project(24'd0, 24'd0, 24'd100, 24'd0, 24'd0, 24'd0);
        project(24'd0, 24'd0, -24'd2000000, 24'd0, 24'd0, 24'd0);
        drain();

        // Random phases over several register settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(pwts_pkg::CFG_WIDTH, (ph < 5) ? widths[ph] : 14'($urandom));
            write_reg(pwts_pkg::CFG_HEIGHT, (ph < 5) ? heights[ph] : 14'($urandom));
            write_reg(pwts_pkg::CFG_MODE, 14'(ph[0]));
            if (ph == 1)
                hold_req = 1'b1;
            // Start each phase from a camera that sees most points.
            load_coef(4'd10, 32'($urandom_range(1, 4 * ONE_Q24)));
            load_coef(4'd11, 32'($urandom_range(0, ONE_Q24 << 6)));
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pwts_pkg.sv
sv/pwts_div.sv
sv/pwts_sqrt.sv
sv/perspective_world_to_screen_top.sv
tb/sv/projection_checker.sv
tb/sv/testbench.sv
